### rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal cursor control package
// Shared constants, micro-word fields and the control and status bundles
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int TAB_STOP_DEFAULT    = 8;
  localparam int WRAP_INDENT_DEFAULT = 13;

  localparam int MAX_RESULTS = 40;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int PC_W        = 5;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;
  localparam logic [7:0] MIN_COLUMNS   = 8'd16;

  localparam logic [7:0] CFG_COLUMNS = 8'd0;
  localparam logic [7:0] CFG_ROWS    = 8'd1;

  localparam logic OP_WRITE       = 1'b0;
  localparam logic OP_MOVE_CURSOR = 1'b1;

  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_END_ESC = 8'h6D;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_BS      = 8'h08;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_LF,
    EM_SPACE,
    EM_BYTE
  } emit_e;

  typedef enum logic [1:0] {
    CO_KEEP,
    CO_ZERO,
    CO_DEC
  } col_e;

  typedef enum logic [1:0] {
    ES_KEEP,
    ES_SET,
    ES_CLR
  } esc_e;

  typedef enum logic [2:0] {
    CN_KEEP,
    CN_LOAD_IND,
    CN_DEC_IND,
    CN_LOAD_TAB,
    CN_DEC_TAB
  } cnt_e;

  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_LF,
    JC_CR,
    JC_NUL,
    JC_BS,
    JC_TAB,
    JC_NOT_FULL,
    JC_IND_ZERO,
    JC_TAB_ZERO
  } cond_e;

  typedef struct packed {
    emit_e emit;
    col_e  col;
    esc_e  esc;
    cnt_e  cnt;
    cond_e cond;
    pc_t   target;
    logic  done;
  } uword_t;

  typedef struct packed {
    logic   active;
    logic   load_byte;
    logic   move_cursor;
    uword_t uw;
  } ctrl_t;

  typedef struct packed {
    logic is_lf;
    logic is_cr;
    logic is_nul;
    logic is_bs;
    logic is_tab;
    logic full;
    logic ind_zero;
    logic tab_zero;
    logic stall;
  } status_t;

endpackage

### rtl/ttc_seq.sv
// ----------------------------------------------------------------------------
// Text terminal cursor control sequencer
// Step counter over a read-only control program, with conditional jumps on
// the datapath status and a hold while the datapath stalls.
// ----------------------------------------------------------------------------
module ttc_seq
  import ttc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    operation_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  localparam pc_t A_IDLE   = 5'd0;
  localparam pc_t A_START  = 5'd1;
  localparam pc_t A_IND    = 5'd4;
  localparam pc_t A_AFTER  = 5'd6;
  localparam pc_t A_CR     = 5'd11;
  localparam pc_t A_BS     = 5'd12;
  localparam pc_t A_TAB    = 5'd13;
  localparam pc_t A_TLOOP  = 5'd14;
  localparam pc_t A_TIND   = 5'd17;
  localparam pc_t A_TPUT   = 5'd19;
  localparam pc_t A_LF     = 5'd20;
  localparam pc_t A_END    = 5'd21;

  function automatic uword_t mk(emit_e em, col_e co, esc_e es, cnt_e cn, cond_e jc,
                                pc_t tgt, logic dn);
    uword_t w;
    w.emit   = em;
    w.col    = co;
    w.esc    = es;
    w.cnt    = cn;
    w.cond   = jc;
    w.target = tgt;
    w.done   = dn;
    return w;
  endfunction

  function automatic uword_t ucode(pc_t a);
    uword_t w;
    w = mk(EM_NONE, CO_KEEP, ES_KEEP, CN_KEEP, JC_NEVER, A_IDLE, 1'b0);
    unique case (a)
      5'd1:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_LF,       A_LF,    1'b0);
      5'd2:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_NOT_FULL, A_AFTER, 1'b0);
      5'd3:  w = mk(EM_LF,    CO_KEEP, ES_KEEP, CN_LOAD_IND, JC_NEVER,    A_IDLE,  1'b0);
      5'd4:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_IND_ZERO, A_AFTER, 1'b0);
      5'd5:  w = mk(EM_SPACE, CO_KEEP, ES_KEEP, CN_DEC_IND,  JC_ALWAYS,   A_IND,   1'b0);
      5'd6:  w = mk(EM_NONE,  CO_KEEP, ES_SET,  CN_KEEP,     JC_CR,       A_CR,    1'b0);
      5'd7:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_NUL,      A_END,   1'b0);
      5'd8:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_BS,       A_BS,    1'b0);
      5'd9:  w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_TAB,      A_TAB,   1'b0);
      5'd10: w = mk(EM_BYTE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_ALWAYS,   A_END,   1'b0);
      5'd11: w = mk(EM_NONE,  CO_ZERO, ES_KEEP, CN_KEEP,     JC_ALWAYS,   A_END,   1'b0);
      5'd12: w = mk(EM_NONE,  CO_DEC,  ES_KEEP, CN_KEEP,     JC_ALWAYS,   A_END,   1'b0);
      5'd13: w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_LOAD_TAB, JC_NEVER,    A_IDLE,  1'b0);
      5'd14: w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_TAB_ZERO, A_END,   1'b0);
      5'd15: w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_NOT_FULL, A_TPUT,  1'b0);
      5'd16: w = mk(EM_LF,    CO_KEEP, ES_KEEP, CN_LOAD_IND, JC_NEVER,    A_IDLE,  1'b0);
      5'd17: w = mk(EM_NONE,  CO_KEEP, ES_KEEP, CN_KEEP,     JC_IND_ZERO, A_TPUT,  1'b0);
      5'd18: w = mk(EM_SPACE, CO_KEEP, ES_KEEP, CN_DEC_IND,  JC_ALWAYS,   A_TIND,  1'b0);
      5'd19: w = mk(EM_SPACE, CO_KEEP, ES_KEEP, CN_DEC_TAB,  JC_ALWAYS,   A_TLOOP, 1'b0);
      5'd20: w = mk(EM_LF,    CO_KEEP, ES_KEEP, CN_KEEP,     JC_ALWAYS,   A_END,   1'b0);
      5'd21: w = mk(EM_NONE,  CO_KEEP, ES_CLR,  CN_KEEP,     JC_NEVER,    A_IDLE,  1'b1);
      default: w = mk(EM_NONE, CO_KEEP, ES_KEEP, CN_KEEP, JC_NEVER, A_IDLE, 1'b0);
    endcase
    return w;
  endfunction

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   active;
  logic   accept;
  logic   taken;

  assign uw         = ucode(pc_q);
  assign active     = (pc_q != A_IDLE);
  assign in_ready_o = !active;
  assign accept     = in_valid_i && !active;

  always_comb begin
    unique case (uw.cond)
      JC_NEVER:    taken = 1'b0;
      JC_ALWAYS:   taken = 1'b1;
      JC_LF:       taken = status_i.is_lf;
      JC_CR:       taken = status_i.is_cr;
      JC_NUL:      taken = status_i.is_nul;
      JC_BS:       taken = status_i.is_bs;
      JC_TAB:      taken = status_i.is_tab;
      JC_NOT_FULL: taken = !status_i.full;
      JC_IND_ZERO: taken = status_i.ind_zero;
      JC_TAB_ZERO: taken = status_i.tab_zero;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (!active) begin
      if (accept && operation_i == OP_WRITE) begin
        pc_d = A_START;
      end
    end else if (!status_i.stall) begin
      priority if (uw.done) begin
        pc_d = A_IDLE;
      end else if (taken) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= A_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.active      = active;
  assign ctrl_o.load_byte   = accept && operation_i == OP_WRITE;
  assign ctrl_o.move_cursor = accept && operation_i == OP_MOVE_CURSOR;
  assign ctrl_o.uw          = uw;

endmodule

### rtl/ttc_datapath.sv
// ----------------------------------------------------------------------------
// Text terminal cursor control datapath
// Cursor, escape and configuration registers, padding counters, a pending
// command register that learns its final flag, and the output register.
// ----------------------------------------------------------------------------
module ttc_datapath
  import ttc_pkg::*;
#(
  parameter int TAB_STOP    = TAB_STOP_DEFAULT,
  parameter int WRAP_INDENT = WRAP_INDENT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  output status_t    status_o,
  input  logic [7:0] byte_in_i,
  input  logic [7:0] new_column_i,
  input  logic [7:0] new_row_i,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       command_o,
  output logic [7:0] column_o,
  output logic [7:0] row_o,
  output logic [7:0] glyph_o,
  output logic       last_o
);

  localparam int IND_W = (WRAP_INDENT > 0) ? $clog2(WRAP_INDENT + 1) : 1;
  localparam int TAB_W = $clog2(TAB_STOP + 1);

  function automatic logic [256*TAB_W-1:0] tab_pad_table();
    logic [256*TAB_W-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*TAB_W +: TAB_W] = TAB_W'(TAB_STOP - (i % TAB_STOP));
    end
    return t;
  endfunction

  localparam logic [256*TAB_W-1:0] TAB_PAD = tab_pad_table();

  logic [7:0]       columns_q, rows_q;
  logic [7:0]       col_q, row_q, byte_q;
  logic             esc_q;
  logic [IND_W-1:0] ind_q;
  logic [TAB_W-1:0] tab_q;
  logic [CNT_W-1:0] cnt_q;

  logic       pend_valid_q;
  logic       pend_cmd_q;
  logic [7:0] pend_col_q, pend_row_q, pend_glyph_q;

  logic       out_valid_q, out_cmd_q, out_last_q;
  logic [7:0] out_col_q, out_row_q, out_glyph_q;

  logic [7:0] eff_cols, eff_rows;
  logic       full, lf_scroll, em_req, will_emit, out_free, stall, go;
  logic       new_cmd;
  logic [7:0] new_col, new_row, new_glyph;
  uword_t     uw;

  assign uw        = ctrl_i.uw;
  assign eff_cols  = (columns_q < MIN_COLUMNS) ? MIN_COLUMNS : columns_q;
  assign eff_rows  = (rows_q == 8'd0) ? 8'd1 : rows_q;
  assign full      = (col_q >= eff_cols);
  assign lf_scroll = ({1'b0, row_q} + 9'd1) >= {1'b0, eff_rows};

  always_comb begin
    em_req    = 1'b0;
    new_cmd   = CMD_PUT;
    new_col   = col_q;
    new_row   = row_q;
    new_glyph = 8'd0;
    unique case (uw.emit)
      EM_NONE: begin
        em_req = 1'b0;
      end
      EM_LF: begin
        em_req  = lf_scroll;
        new_cmd = CMD_SCROLL;
        new_col = 8'd0;
        new_row = 8'd0;
      end
      EM_SPACE: begin
        em_req    = 1'b1;
        new_glyph = BYTE_SPACE;
      end
      EM_BYTE: begin
        em_req    = 1'b1;
        new_glyph = byte_q;
      end
    endcase
  end

  assign will_emit = ctrl_i.active && em_req && (cnt_q < CNT_W'(MAX_RESULTS));
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = ctrl_i.active && (will_emit || uw.done) && pend_valid_q && !out_free;
  assign go        = ctrl_i.active && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_COLUMNS) begin
        columns_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 8'd0;
      esc_q <= 1'b0;
    end else if (ctrl_i.move_cursor) begin
      col_q <= new_column_i;
      row_q <= new_row_i;
    end else if (go) begin
      unique case (uw.emit)
        EM_LF: begin
          row_q <= lf_scroll ? (eff_rows - 8'd1) : (row_q + 8'd1);
          col_q <= 8'd0;
        end
        EM_SPACE, EM_BYTE: begin
          if (!esc_q && col_q != 8'd255) begin
            col_q <= col_q + 8'd1;
          end
        end
        default: begin
        end
      endcase
      unique case (uw.col)
        CO_ZERO: col_q <= 8'd0;
        CO_DEC: begin
          if (col_q != 8'd0) begin
            col_q <= col_q - 8'd1;
          end
        end
        default: begin
        end
      endcase
      unique case (uw.esc)
        ES_SET: begin
          if (byte_q == BYTE_ESC) begin
            esc_q <= 1'b1;
          end
        end
        ES_CLR: begin
          if (byte_q == BYTE_END_ESC) begin
            esc_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_byte) begin
      byte_q <= byte_in_i;
    end
    if (go) begin
      unique case (uw.cnt)
        CN_LOAD_IND: ind_q <= IND_W'(WRAP_INDENT);
        CN_DEC_IND:  ind_q <= ind_q - IND_W'(1);
        CN_LOAD_TAB: tab_q <= TAB_PAD[int'(col_q)*TAB_W +: TAB_W];
        CN_DEC_TAB:  tab_q <= tab_q - TAB_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.load_byte) begin
        cnt_q <= '0;
      end else if (go && will_emit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (go && will_emit) begin
        pend_valid_q <= 1'b1;
      end else if (go && uw.done) begin
        pend_valid_q <= 1'b0;
      end
      if (go && pend_valid_q && (will_emit || uw.done)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && will_emit) begin
      pend_cmd_q   <= new_cmd;
      pend_col_q   <= new_col;
      pend_row_q   <= new_row;
      pend_glyph_q <= new_glyph;
    end
    if (go && pend_valid_q && (will_emit || uw.done)) begin
      out_cmd_q   <= pend_cmd_q;
      out_col_q   <= pend_col_q;
      out_row_q   <= pend_row_q;
      out_glyph_q <= pend_glyph_q;
      out_last_q  <= uw.done;
    end
  end

  assign status_o.is_lf    = (byte_q == BYTE_LF);
  assign status_o.is_cr    = (byte_q == BYTE_CR);
  assign status_o.is_nul   = (byte_q == BYTE_NUL);
  assign status_o.is_bs    = (byte_q == BYTE_BS);
  assign status_o.is_tab   = (byte_q == BYTE_TAB);
  assign status_o.full     = full;
  assign status_o.ind_zero = (ind_q == '0);
  assign status_o.tab_zero = (tab_q == '0);
  assign status_o.stall    = stall;

  assign out_valid_o = out_valid_q;
  assign command_o   = out_cmd_q;
  assign column_o    = out_col_q;
  assign row_o       = out_row_q;
  assign glyph_o     = out_glyph_q;
  assign last_o      = out_last_q;

endmodule

### rtl/text_terminal_cursor_control.sv
// ----------------------------------------------------------------------------
// Text terminal cursor control
// Turns console bytes and cursor moves into put-glyph and scroll commands,
// driven by a small control program over the cursor datapath.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_ready_o   operation, byte_in, new_column, new_row
//  out      output     out_valid_o / out_ready_i command, column, row, glyph, last
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  A cursor move loads the cursor registers and does not start the program. A
//  byte runs the control program, one control word per cycle unless a stall
//  holds it, and the next request waits until the program is done; a tab pads
//  with spaces, and each wrap adds a line feed and WRAP_INDENT indent spaces.
//  Each command waits in a pending register until the next is made, so a
//  full output register stalls the program. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module text_terminal_cursor_control
  import ttc_pkg::*;
#(
  parameter int TAB_STOP    = TAB_STOP_DEFAULT,
  parameter int WRAP_INDENT = WRAP_INDENT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] byte_in_i,
  input  logic [7:0] new_column_i,
  input  logic [7:0] new_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       command_o,
  output logic [7:0] column_o,
  output logic [7:0] row_o,
  output logic [7:0] glyph_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ttc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  ttc_datapath #(
    .TAB_STOP    (TAB_STOP),
    .WRAP_INDENT (WRAP_INDENT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .byte_in_i    (byte_in_i),
    .new_column_i (new_column_i),
    .new_row_i    (new_row_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .column_o     (column_o),
    .row_o        (row_o),
    .glyph_o      (glyph_o),
    .last_o       (last_o)
  );

  a_idle_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.active |-> !status.stall)
    else $error("stall raised while the sequencer is idle");

  a_move_stays_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == OP_MOVE_CURSOR) |=> in_ready_o)
    else $error("cursor move request did not complete in one cycle");

  a_write_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == OP_WRITE) |=> !in_ready_o)
    else $error("byte request did not start the program");

  a_scroll_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o == CMD_SCROLL) |->
      (column_o == 8'd0 && row_o == 8'd0 && glyph_o == 8'd0))
    else $error("scroll command carries a non-zero position or glyph");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Text terminal cursor control testbench
// Drives console bytes and cursor moves through the request channel, writes
// the console geometry between phases and compares every screen command with
// a table entry or a cycle-free model of the cursor, the escape flag and the
// wrap and tab padding. A directed table comes first, then random phases over
// several geometries, with random idling on both channels but in one phase.
// ----------------------------------------------------------------------------
module tb;
  import ttc_pkg::*;

  localparam int TAB_STOP      = TAB_STOP_DEFAULT;
  localparam int WRAP_INDENT   = WRAP_INDENT_DEFAULT;
  localparam int SETTLE_CYCLES = 64;
  localparam int TIMEOUT_UNITS = 5_000_000;
  localparam int PHASE_ITEMS   = 18;

  typedef struct packed {
    logic       command;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] glyph;
    logic       last;
  } screen_cmd_t;

  typedef struct packed {
    logic        geom;
    logic        op;
    logic [7:0]  data;
    logic [7:0]  ncol;
    logic [7:0]  nrow;
    logic        typed;
    screen_cmd_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       operation = OP_WRITE;
  logic [7:0] byte_in = 8'd0;
  logic [7:0] new_column = 8'd0;
  logic [7:0] new_row = 8'd0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_index = CFG_COLUMNS;
  logic [7:0] cfg_data = 8'd0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       command_o;
  logic [7:0] column_o;
  logic [7:0] row_o;
  logic [7:0] glyph_o;
  logic       last_o;
  logic       cfg_ready_o;

  logic [7:0] cur_columns;
  logic [7:0] cur_rows;
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       cur_esc;

  screen_cmd_t expected_cmds[$];
  screen_cmd_t step_cmds[$];
  stim_row_t   directed[$];
  logic        no_idle = 1'b0;
  int          fails = 0;

  always #5 clk_i = ~clk_i;

  text_terminal_cursor_control #(
    .TAB_STOP   (TAB_STOP),
    .WRAP_INDENT(WRAP_INDENT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (operation),
    .byte_in_i   (byte_in),
    .new_column_i(new_column),
    .new_row_i   (new_row),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .command_o   (command_o),
    .column_o    (column_o),
    .row_o       (row_o),
    .glyph_o     (glyph_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  function automatic int width_cells();
    return (cur_columns < MIN_COLUMNS) ? int'(MIN_COLUMNS) : int'(cur_columns);
  endfunction

  function automatic int height_rows();
    return (cur_rows == 8'd0) ? 1 : int'(cur_rows);
  endfunction

  task automatic emit_cmd(input logic cmd, input logic [7:0] col, input logic [7:0] row,
                          input logic [7:0] glyph);
    if (step_cmds.size() < MAX_RESULTS) step_cmds.push_back('{cmd, col, row, glyph, 1'b0});
  endtask

  task automatic feed_line();
    if (int'(cur_row) + 1 >= height_rows()) begin
      emit_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0);
      cur_row = 8'(height_rows() - 1);
    end else begin
      cur_row = cur_row + 8'd1;
    end
    cur_col = 8'd0;
  endtask

  task automatic put_at_cursor(input logic [7:0] glyph);
    emit_cmd(CMD_PUT, cur_col, cur_row, glyph);
    if (!cur_esc && cur_col != 8'd255) cur_col = cur_col + 8'd1;
  endtask

  task automatic wrap_when_full();
    if (int'(cur_col) >= width_cells()) begin
      feed_line();
      repeat (WRAP_INDENT) put_at_cursor(BYTE_SPACE);
    end
  endtask

  task automatic predict_screen(input logic op, input logic [7:0] b, input logic [7:0] c,
                                input logic [7:0] r);
    int pad;
    step_cmds.delete();
    if (op == OP_MOVE_CURSOR) begin
      cur_col = c;
      cur_row = r;
    end else begin
      if (b != BYTE_LF) wrap_when_full();
      if (b == BYTE_ESC) cur_esc = 1'b1;
      case (b)
        BYTE_LF: feed_line();
        BYTE_CR: cur_col = 8'd0;
        BYTE_NUL: ;
        BYTE_BS: if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
        BYTE_TAB: begin
          pad = TAB_STOP - (int'(cur_col) % TAB_STOP);
          repeat (pad) begin
            wrap_when_full();
            put_at_cursor(BYTE_SPACE);
          end
        end
        default: put_at_cursor(b);
      endcase
      if (b == BYTE_END_ESC) cur_esc = 1'b0;
      if (step_cmds.size() > 0) step_cmds[$].last = 1'b1;
    end
  endtask

  task automatic send_request(input logic op, input logic [7:0] b, input logic [7:0] c,
                              input logic [7:0] r, input logic typed, input screen_cmd_t want);
    while (!no_idle && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    byte_in    <= b;
    new_column <= c;
    new_row    <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_screen(op, b, c, r);
    if (typed) expected_cmds.push_back(want);
    else foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [7:0] cols, input logic [7:0] nrows);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_columns = cols;
    cfg_index <= CFG_ROWS;
    cfg_data  <= nrows;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_rows = nrows;
    cfg_valid <= 1'b0;
  endtask

  task automatic row_item(input logic op, input logic [7:0] b, input logic [7:0] c,
                          input logic [7:0] r);
    directed.push_back('{1'b0, op, b, c, r, 1'b0, '0});
  endtask

  task automatic row_typed(input logic [7:0] b, input logic cmd, input logic [7:0] col,
                           input logic [7:0] row, input logic [7:0] glyph);
    directed.push_back('{1'b0, OP_WRITE, b, 8'd0, 8'd0, 1'b1, '{cmd, col, row, glyph, 1'b1}});
  endtask

  task automatic row_geom(input logic [7:0] cols, input logic [7:0] nrows);
    directed.push_back('{1'b1, OP_WRITE, 8'd0, cols, nrows, 1'b0, '0});
  endtask

  task automatic random_request();
    logic [7:0] specials[7];
    logic       op;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] r;
    int         k;
    specials = '{BYTE_LF, BYTE_CR, BYTE_NUL, BYTE_BS, BYTE_TAB, BYTE_ESC, BYTE_END_ESC};
    k  = $urandom_range(0, 99);
    op = OP_WRITE;
    b  = 8'($urandom);
    c  = 8'($urandom);
    r  = 8'($urandom);
    if (k < 15) begin
      op = OP_MOVE_CURSOR;
      if ($urandom_range(0, 1) == 1) c = 8'(width_cells() - $urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) r = 8'(height_rows() - 1);
    end else if (k < 45) begin
      b = specials[$urandom_range(0, 6)];
    end
    send_request(op, b, c, r, 1'b0, '0);
  endtask

  // Output side: check each accepted command, then choose the next ready.
  always @(posedge clk_i) begin
    screen_cmd_t got;
    screen_cmd_t want;
    got = '{command_o, column_o, row_o, glyph_o, last_o};
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_cmds.size() == 0) begin
        if (fails < 10)
          $display("unexpected command %0d col %0d row %0d glyph %02h last %0d",
                   got.command, got.column, got.row, got.glyph, got.last);
        fails++;
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          if (fails < 10)
            $display({"mismatch: expected cmd %0d col %0d row %0d glyph %02h last %0d,",
                      " got cmd %0d col %0d row %0d glyph %02h last %0d"},
                     want.command, want.column, want.row, want.glyph, want.last,
                     got.command, got.column, got.row, got.glyph, got.last);
          fails++;
        end
      end
    end
    out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    cur_columns = COLUMNS_RESET;
    cur_rows    = ROWS_RESET;
    cur_col     = 8'd0;
    cur_row     = 8'd0;
    cur_esc     = 1'b0;

    // Default geometry of 80 by 25.
    row_typed(8'h41, CMD_PUT, 8'd0, 8'd0, 8'h41);
    row_item(OP_WRITE, BYTE_NUL, 8'd0, 8'd0);
    row_item(OP_WRITE, BYTE_BS, 8'd0, 8'd0);
    row_item(OP_WRITE, BYTE_BS, 8'd0, 8'd0);
    row_typed(8'h42, CMD_PUT, 8'd0, 8'd0, 8'h42);
    row_item(OP_WRITE, BYTE_TAB, 8'd0, 8'd0);
    row_item(OP_WRITE, BYTE_CR, 8'd0, 8'd0);
    row_item(OP_WRITE, BYTE_LF, 8'd0, 8'd0);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd79, 8'd24);
    row_typed(8'h7A, CMD_PUT, 8'd79, 8'd24, 8'h7A);
    row_item(OP_WRITE, 8'h42, 8'd0, 8'd0);
    row_item(OP_MOVE_CURSOR, 8'hFF, 8'd255, 8'd255);
    row_typed(BYTE_LF, CMD_SCROLL, 8'd0, 8'd0, 8'd0);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd0, 8'd0);
    row_typed(BYTE_ESC, CMD_PUT, 8'd0, 8'd0, BYTE_ESC);
    row_item(OP_WRITE, BYTE_TAB, 8'd0, 8'd0);
    row_typed(BYTE_END_ESC, CMD_PUT, 8'd0, 8'd0, BYTE_END_ESC);
    row_typed(8'hFF, CMD_PUT, 8'd0, 8'd0, 8'hFF);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd250, 8'd3);
    row_item(OP_WRITE, BYTE_CR, 8'd0, 8'd0);
    // A tab that wraps twice on a single-row console of 17 cells.
    row_geom(8'd17, 8'd1);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd16, 8'd0);
    row_item(OP_WRITE, BYTE_TAB, 8'd0, 8'd0);
    // Width below the minimum and zero height.
    row_geom(8'd0, 8'd0);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd16, 8'd0);
    row_item(OP_WRITE, BYTE_NUL, 8'd0, 8'd0);
    row_typed(BYTE_LF, CMD_SCROLL, 8'd0, 8'd0, 8'd0);
    row_geom(8'd255, 8'd255);
    row_item(OP_MOVE_CURSOR, 8'd0, 8'd254, 8'd254);
    row_typed(8'h78, CMD_PUT, 8'd254, 8'd254, 8'h78);
    row_typed(BYTE_LF, CMD_SCROLL, 8'd0, 8'd0, 8'd0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].geom)
        write_geometry(directed[i].ncol, directed[i].nrow);
      else
        send_request(directed[i].op, directed[i].data, directed[i].ncol, directed[i].nrow,
                     directed[i].typed, directed[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_geometry(8'($urandom_range(16, 40)), 8'($urandom_range(1, 4)));
        1: write_geometry(8'd255, 8'($urandom));
        2: write_geometry(8'($urandom_range(0, 15)), 8'd1);
        default: write_geometry(8'($urandom), 8'($urandom));
      endcase
      no_idle = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        if ($urandom_range(0, 99) < 3) drain();
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0 && expected_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
